### rtl/pue_pkg.sv
// ----------------------------------------------------------------------------
// Particle update engine package
// Shared sizes, command and register codes, the particle record and a clamp helper.
// ----------------------------------------------------------------------------
package pue_pkg;

  // table size and derived widths
  localparam int NUM_PARTICLES = 64;
  localparam int IDX_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int MAX_N = (NUM_PARTICLES < 64) ? NUM_PARTICLES : 64;

  // request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // motion modes
  localparam logic MODE_DROP   = 1'b0;
  localparam logic MODE_SPREAD = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_LOOP    = 3'd1,
    CFG_PIVOT_X = 3'd2,
    CFG_PIVOT_Y = 3'd3,
    CFG_PIVOT_Z = 3'd4,
    CFG_COUNT   = 3'd5
  } cfg_idx_e;

  // one particle table entry
  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic signed [31:0] home_z;
    logic signed [31:0] speed;
    logic [30:0]        life_max;
    logic [30:0]        elapsed;
  } rec_t;

  // clamp to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/pue_table.sv
// ----------------------------------------------------------------------------
// Particle table
// One-port-write, one-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module pue_table (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [pue_pkg::IDX_W-1:0] waddr_i,
  input  pue_pkg::rec_t           wdata_i,
  input  logic                    re_i,
  input  logic [pue_pkg::IDX_W-1:0] raddr_i,
  output pue_pkg::rec_t           rdata_o
);
  import pue_pkg::*;

  rec_t mem_q [NUM_PARTICLES];
  rec_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

### rtl/pue_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32x32 multiply with a registered 64 bit product.
// ----------------------------------------------------------------------------
module pue_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

### rtl/particle_update_engine_top.sv
// ----------------------------------------------------------------------------
// Particle update engine
// Particle table with a sequencer that walks active entries on each tick.
// ----------------------------------------------------------------------------
// A load request is written as it is accepted and busy stays low. A tick
// request walks entries 0..n-1 one at a time, n = min(count register, 64);
// each entry gives one result strobe (result_valid_o) that the receiver
// cannot stall. In spread mode an entry takes a 32 step square root and
// three 17 step divisions, all sharing one multiplier; a particle that sits
// on the pivot skips the divisions and the move. A tick with n of zero gives
// no result.
// ----------------------------------------------------------------------------
module particle_update_engine_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic                cmd_i,
  input  logic [5:0]          slot_i,
  input  logic signed [31:0]  start_x_i,
  input  logic signed [31:0]  start_y_i,
  input  logic signed [31:0]  start_z_i,
  input  logic signed [31:0]  velocity_i,
  input  logic [30:0]         life_limit_i,
  input  logic [30:0]         time_step_i,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  // results
  output logic                result_valid_o,
  output logic [5:0]          entry_o,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic [30:0]         age_o,
  output logic                restarted_o,
  output logic                last_o
);
  import pue_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_RD   = 15'b000000000000010,
    ST_SPD  = 15'b000000000000100,
    ST_D    = 15'b000000000001000,
    ST_SQ   = 15'b000000000010000,
    ST_ACC  = 15'b000000000100000,
    ST_SQRT = 15'b000000001000000,
    ST_LEN  = 15'b000000010000000,
    ST_DIVI = 15'b000000100000000,
    ST_DIV  = 15'b000001000000000,
    ST_M0   = 15'b000010000000000,
    ST_M1   = 15'b000100000000000,
    ST_M2   = 15'b001000000000000,
    ST_ADD  = 15'b010000000000000,
    ST_WB   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic               mode_q, loop_q;
  logic signed [31:0] pivot_q [3];
  logic [6:0]         count_q;

  // control
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       k_q;
  logic [6:0]       n_q;
  logic [30:0]      step_q;
  logic [4:0]       div_cnt_q;

  // datapath
  logic signed [31:0] cur_q [3];
  logic signed [32:0] v_q [3];
  logic [31:0]        a_mag_q [3];
  logic [2:0]         a_neg_q;
  logic [46:0]        d_mag_q;
  logic               d_neg_q;
  logic [63:0]        acc_q, n_rem_q, r_q, bit_q;
  logic [31:0]        len_q, rem_q;
  logic [16:0]        sh_q, q_q;
  logic [48:0]        pl_q;
  logic [47:0]        dm_q;
  logic               neg_q;

  // outputs
  logic               res_valid_q, rs_q, last_q;
  logic [5:0]         entry_q;
  logic signed [31:0] pos_q [3];
  logic [30:0]        age_q;

  // table and multiplier hookup
  logic             tb_we, tb_re;
  logic [IDX_W-1:0] tb_waddr;
  rec_t             tb_wdata, rd;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  logic accept, load_ok, tick_go;
  logic [6:0] n_tick;
  logic [31:0] speed_mag;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign n_tick      = (count_q > 7'(MAX_N)) ? 7'(MAX_N) : count_q;
  assign load_ok     = accept && (cmd_i == CMD_LOAD) &&
                       ({26'd0, slot_i} < 32'(NUM_PARTICLES));
  assign tick_go     = accept && (cmd_i == CMD_TICK) && (n_tick != 7'd0);
  assign speed_mag   = rd.speed[31] ? (32'd0 - rd.speed) : rd.speed;

  pue_table u_table (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (tb_wdata),
    .re_i    (tb_re),
    .raddr_i (idx_q),
    .rdata_o (rd)
  );

  pue_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      ST_SPD: begin
        mul_a = speed_mag;
        mul_b = {1'b0, step_q};
      end
      ST_SQ: begin
        mul_a = a_mag_q[k_q];
        mul_b = a_mag_q[k_q];
      end
      ST_M0: begin
        mul_a = d_mag_q[31:0];
        mul_b = {15'd0, q_q};
      end
      ST_M1: begin
        mul_a = {17'd0, d_mag_q[46:32]};
        mul_b = {15'd0, q_q};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // magnitudes and pre-scale of the pivot vector
  logic [32:0] v_mag [3];
  logic        v_big;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_mag[i] = v_q[i][32] ? (33'd0 - v_q[i]) : v_q[i];
    end
    v_big = v_mag[0][32] | v_mag[0][31] | v_mag[1][32] | v_mag[1][31] |
            v_mag[2][32] | v_mag[2][31];
  end

  // square root step
  logic [63:0] sq_trial;
  logic        sq_ge;
  assign sq_trial = r_q + bit_q;
  assign sq_ge    = (n_rem_q >= sq_trial);

  // division step
  logic [32:0] dv_t, dv_diff;
  logic        dv_ge;
  assign dv_t    = {rem_q, sh_q[16]};
  assign dv_ge   = (dv_t >= {1'b0, len_q});
  assign dv_diff = dv_t - {1'b0, len_q};

  // saturating position add
  logic [49:0]        add_dlt;
  logic signed [49:0] add_sum;
  logic signed [31:0] add_res;
  assign add_dlt = neg_q ? (50'd0 - {2'b0, dm_q}) : {2'b0, dm_q};
  assign add_sum = $signed({{18{cur_q[k_q][31]}}, cur_q[k_q]} + add_dlt);
  assign add_res = sat32(add_sum);

  // lifetime update and restart
  logic [31:0] e_sum;
  logic [30:0] e_sat;
  logic        e_rst;
  logic        is_last;
  assign e_sum   = {1'b0, rd.elapsed} + {1'b0, step_q};
  assign e_sat   = e_sum[31] ? 31'h7FFFFFFF : e_sum[30:0];
  assign e_rst   = loop_q && (e_sat >= rd.life_max);
  assign is_last = ((7'(idx_q) + 7'd1) == n_q);

  // table write port
  always_comb begin
    tb_re    = (state_q == ST_RD);
    tb_we    = 1'b0;
    tb_waddr = idx_q;
    tb_wdata = rd;
    if (load_ok) begin
      tb_we             = 1'b1;
      tb_waddr          = slot_i[IDX_W-1:0];
      tb_wdata.cur_x    = start_x_i;
      tb_wdata.cur_y    = start_y_i;
      tb_wdata.cur_z    = start_z_i;
      tb_wdata.home_x   = start_x_i;
      tb_wdata.home_y   = start_y_i;
      tb_wdata.home_z   = start_z_i;
      tb_wdata.speed    = velocity_i;
      tb_wdata.life_max = life_limit_i;
      tb_wdata.elapsed  = 31'd0;
    end else if (state_q == ST_WB) begin
      tb_we            = 1'b1;
      tb_wdata.cur_x   = e_rst ? rd.home_x : cur_q[0];
      tb_wdata.cur_y   = e_rst ? rd.home_y : cur_q[1];
      tb_wdata.cur_z   = e_rst ? rd.home_z : cur_q[2];
      tb_wdata.elapsed = e_rst ? 31'd0 : e_sat;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tick_go) state_d = ST_RD;
      ST_RD:   state_d = ST_SPD;
      ST_SPD:  state_d = ST_D;
      ST_D:    state_d = (mode_q == MODE_DROP) ? ST_ADD : ST_SQ;
      ST_SQ:   state_d = ST_ACC;
      ST_ACC:  state_d = (k_q == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT: if (bit_q == 64'd1) state_d = ST_LEN;
      ST_LEN:  state_d = (r_q == 64'd0) ? ST_WB : ST_DIVI;
      ST_DIVI: state_d = ST_DIV;
      ST_DIV:  if (div_cnt_q == 5'd16) state_d = ST_M0;
      ST_M0:   state_d = ST_M1;
      ST_M1:   state_d = ST_M2;
      ST_M2:   state_d = ST_ADD;
      ST_ADD:  state_d = ((mode_q == MODE_DROP) || (k_q == 2'd2)) ? ST_WB : ST_DIVI;
      ST_WB:   state_d = is_last ? ST_IDLE : ST_RD;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      k_q         <= 2'd0;
      n_q         <= 7'd0;
      div_cnt_q   <= 5'd0;
      res_valid_q <= 1'b0;
      mode_q      <= MODE_DROP;
      loop_q      <= 1'b0;
      pivot_q[0]  <= 32'sd0;
      pivot_q[1]  <= 32'sd0;
      pivot_q[2]  <= 32'sd0;
      count_q     <= 7'd64;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_WB);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:    mode_q     <= cfg_data_i[0];
          CFG_LOOP:    loop_q     <= cfg_data_i[0];
          CFG_PIVOT_X: pivot_q[0] <= cfg_data_i;
          CFG_PIVOT_Y: pivot_q[1] <= cfg_data_i;
          CFG_PIVOT_Z: pivot_q[2] <= cfg_data_i;
          CFG_COUNT:   count_q    <= cfg_data_i[6:0];
          default:     ;
        endcase
      end
      if (tick_go) begin
        n_q   <= n_tick;
        idx_q <= '0;
      end
      if (state_q == ST_WB && !is_last) idx_q <= idx_q + 1'b1;
      unique case (state_q)
        ST_D:    k_q <= (mode_q == MODE_DROP) ? 2'd1 : 2'd0;
        ST_ACC:  if (k_q != 2'd2) k_q <= k_q + 2'd1;
        ST_LEN:  k_q <= 2'd0;
        ST_ADD:  if (k_q != 2'd2) k_q <= k_q + 2'd1;
        default: ;
      endcase
      if (state_q == ST_DIVI) div_cnt_q <= 5'd0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 5'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (tick_go) step_q <= time_step_i;
    unique case (state_q)
      ST_SPD: begin
        cur_q[0] <= rd.cur_x;
        cur_q[1] <= rd.cur_y;
        cur_q[2] <= rd.cur_z;
        v_q[0]   <= 33'(rd.cur_x) - 33'(pivot_q[0]);
        v_q[1]   <= 33'(rd.cur_y) - 33'(pivot_q[1]);
        v_q[2]   <= 33'(rd.cur_z) - 33'(pivot_q[2]);
      end
      ST_D: begin
        d_mag_q <= mul_p[62:16];
        d_neg_q <= rd.speed[31];
        dm_q    <= {1'b0, mul_p[62:16]};
        neg_q   <= ~rd.speed[31];
        acc_q   <= 64'd0;
        for (int i = 0; i < 3; i++) begin
          a_mag_q[i] <= v_big ? v_mag[i][32:1] : v_mag[i][31:0];
          a_neg_q[i] <= v_q[i][32];
        end
      end
      ST_ACC: begin
        acc_q   <= acc_q + mul_p;
        n_rem_q <= acc_q + mul_p;
        r_q     <= 64'd0;
        bit_q   <= 64'd1 << 62;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          n_rem_q <= n_rem_q - sq_trial;
          r_q     <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_LEN: len_q <= r_q[31:0];
      ST_DIVI: begin
        rem_q <= {1'b0, a_mag_q[k_q][31:1]};
        sh_q  <= {a_mag_q[k_q][0], 16'd0};
        q_q   <= 17'd0;
      end
      ST_DIV: begin
        rem_q <= dv_ge ? dv_diff[31:0] : dv_t[31:0];
        sh_q  <= {sh_q[15:0], 1'b0};
        q_q   <= {q_q[15:0], dv_ge};
      end
      ST_M1: pl_q <= mul_p[48:0];
      ST_M2: begin
        dm_q  <= 48'(({mul_p[31:0], 32'd0} + {15'd0, pl_q}) >> 16);
        neg_q <= d_neg_q ^ a_neg_q[k_q];
      end
      ST_ADD: cur_q[k_q] <= add_res;
      ST_WB: begin
        entry_q  <= 6'(idx_q);
        pos_q[0] <= e_rst ? rd.home_x : cur_q[0];
        pos_q[1] <= e_rst ? rd.home_y : cur_q[1];
        pos_q[2] <= e_rst ? rd.home_z : cur_q[2];
        age_q    <= e_rst ? 31'd0 : e_sat;
        rs_q     <= e_rst;
        last_q   <= is_last;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign entry_o        = entry_q;
  assign pos_x_o        = pos_q[0];
  assign pos_y_o        = pos_q[1];
  assign pos_z_o        = pos_q[2];
  assign age_o          = age_q;
  assign restarted_o    = rs_q;
  assign last_o         = last_q;

`ifndef NO_ASSERTIONS
  // the final result of a tick leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> state_q == ST_IDLE)
    else $error("last result while sequencer still busy");

  // after a write-back the next entry starts again at ST_RD, so strobes never touch
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes on back-to-back cycles");

  // unit vector component never exceeds one
  a_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_M0 |-> q_q <= 17'd65536)
    else $error("unit component out of range");

  // results only come from a tick with a nonzero entry count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> n_q != 7'd0)
    else $error("result from an empty tick");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Particle update engine testbench
// Loads particle entries, sends ticks under several register settings and
// checks every result strobe against a predicted particle table.
// ----------------------------------------------------------------------------
module tb_top;
  import pue_pkg::*;

  // one expected result
  typedef struct {
    bit [5:0]  entry;
    bit [31:0] px, py, pz;
    bit [30:0] age;
    bit        rs, last;
  } particle_res_t;

  // predicted particle table and the results it still owes
  class particle_scoreboard;
    bit        mode, loop_en;
    longint    piv[3];
    bit [6:0]  count;
    longint    cur[64][3], home[64][3], speed[64];
    longint    lmax[64], elapsed[64];
    particle_res_t owed[$];
    int        mismatches;

    function new();
      mode = MODE_DROP; loop_en = 0; count = 7'd64;
      piv[0] = 0; piv[1] = 0; piv[2] = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [31:0] data);
      case (idx)
        CFG_MODE:    mode = data[0];
        CFG_LOOP:    loop_en = data[0];
        CFG_PIVOT_X: piv[0] = longint'($signed(data));
        CFG_PIVOT_Y: piv[1] = longint'($signed(data));
        CFG_PIVOT_Z: piv[2] = longint'($signed(data));
        CFG_COUNT:   count = data[6:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // shift right, rounding toward zero
    function longint shr0(longint x, int k);
      if (x < 0) return -((-x) >> k);
      return x >> k;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // move away from the pivot along the unit vector
    function void spread(int i, longint d);
      longint v[3], a[3], u;
      longint unsigned mx, sum, len, m;
      int sh;
      mx = 0; sum = 0; sh = 0;
      for (int k = 0; k < 3; k++) begin
        v[k] = cur[i][k] - piv[k];
        m = (v[k] < 0) ? -v[k] : v[k];
        if (m > mx) mx = m;
      end
      if (mx >= 64'h80000000) sh = 1;
      for (int k = 0; k < 3; k++) begin
        a[k] = shr0(v[k], sh);
        m = (a[k] < 0) ? -a[k] : a[k];
        sum += m * m;
      end
      len = root(sum);
      if (len == 0) return;
      for (int k = 0; k < 3; k++) begin
        u = (a[k] * 65536) / longint'(len);
        cur[i][k] = clamp32(cur[i][k] + shr0(d * u, 16));
      end
    endfunction

    // accepted request
    function void note(bit c, bit [5:0] sl, bit [31:0] sx, bit [31:0] sy,
                       bit [31:0] sz, bit [31:0] vel, bit [30:0] lim,
                       bit [30:0] step);
      int n;
      longint d, e;
      particle_res_t r;
      if (c == CMD_LOAD) begin
        cur[sl][0] = longint'($signed(sx)); home[sl][0] = cur[sl][0];
        cur[sl][1] = longint'($signed(sy)); home[sl][1] = cur[sl][1];
        cur[sl][2] = longint'($signed(sz)); home[sl][2] = cur[sl][2];
        speed[sl] = longint'($signed(vel));
        lmax[sl] = lim; elapsed[sl] = 0;
        return;
      end
      n = (count > 64) ? 64 : count;
      for (int i = 0; i < n; i++) begin
        d = shr0(speed[i] * longint'(step), 16);
        if (mode == MODE_DROP) cur[i][1] = clamp32(cur[i][1] - d);
        else spread(i, d);
        e = elapsed[i] + step;
        if (e > 64'h7FFFFFFF) e = 64'h7FFFFFFF;
        r.rs = 0;
        if (loop_en && e >= lmax[i]) begin
          e = 0;
          for (int k = 0; k < 3; k++) cur[i][k] = home[i][k];
          r.rs = 1;
        end
        elapsed[i] = e;
        r.entry = i; r.px = cur[i][0]; r.py = cur[i][1]; r.pz = cur[i][2];
        r.age = e; r.last = (i + 1 == n);
        owed.push_back(r);
      end
    endfunction

    function void check(particle_res_t got);
      particle_res_t x;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for entry %0d", got.entry);
        return;
      end
      x = owed.pop_front();
      if (x != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp e%0d %h %h %h age %h rs%0d l%0d / got e%0d %h %h %h age %h rs%0d l%0d",
                   x.entry, x.px, x.py, x.pz, x.age, x.rs, x.last,
                   got.entry, got.px, got.py, got.pz, got.age, got.rs, got.last);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start = 0, busy, cmd_i = 0;
  logic [5:0] slot_i = 0;
  logic signed [31:0] start_x_i = 0, start_y_i = 0, start_z_i = 0, velocity_i = 0;
  logic [30:0] life_limit_i = 0, time_step_i = 0;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [2:0] cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic result_valid_o, restarted_o, last_o;
  logic [5:0] entry_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [30:0] age_o;

  particle_scoreboard sb = new();
  bit loaded[64];
  int burst_left = 0;
  bit gaps_on = 1;

  always #5 clk_i = ~clk_i;

  particle_update_engine_top dut (.*);

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check('{entry_o, pos_x_o, pos_y_o, pos_z_o, age_o, restarted_o, last_o});
  end

  // send one request, with random gaps between bursts
  task automatic send(bit c, bit [5:0] sl, bit [31:0] sx, bit [31:0] sy,
                      bit [31:0] sz, bit [31:0] vel, bit [30:0] lim, bit [30:0] step);
    @(negedge clk_i);
    if (gaps_on && burst_left == 0) begin
      start = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    cmd_i = c; slot_i = sl; start_x_i = sx; start_y_i = sy; start_z_i = sz;
    velocity_i = vel; life_limit_i = lim; time_step_i = step; start = 1;
    do @(posedge clk_i); while (busy);
    sb.note(c, sl, sx, sy, sz, vel, lim, step);
    if (c == CMD_LOAD) loaded[sl] = 1;
  endtask

  task automatic load(bit [5:0] sl, bit [31:0] sx, bit [31:0] sy, bit [31:0] sz,
                      bit [31:0] vel, bit [30:0] lim);
    send(CMD_LOAD, sl, sx, sy, sz, vel, lim, $urandom());
  endtask

  task automatic tick(bit [30:0] step);
    send(CMD_TICK, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), step);
  endtask

  // register write; caller makes sure the block is idle
  task automatic write_reg(cfg_idx_e idx, bit [31:0] data);
    @(negedge clk_i);
    start = 0;
    cfg_valid_i = 1; cfg_index_i = idx; cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  // wait for all owed results, then for the walk to wind down
  task automatic drain();
    @(negedge clk_i);
    start = 0;
    while (sb.owed.size() > 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  // make sure every walked entry has been loaded
  task automatic fill_to(int n);
    for (int i = 0; i < n && i < 64; i++)
      if (!loaded[i]) load(i, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  function automatic bit [31:0] pick_pivot();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  // timeout
  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int cnt;
    bit md;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes, both modes, loop, pivot case, empty tick
    write_reg(CFG_COUNT, 4);
    load(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
    load(1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 31'h0);
    load(2, 0, 0, 0, 32'h00010000, 31'h00020000);
    load(3, $urandom(), $urandom(), $urandom(), 32'hFFFF0000, 31'h00030000);
    load(63, $urandom(), $urandom(), $urandom(), $urandom(), 31'h7FFFFFFF);
    tick(31'h7FFFFFFF);
    tick(31'h0);
    tick(31'h00010000);
    drain();
    write_reg(CFG_MODE, MODE_SPREAD);
    tick(31'h00010000);
    tick(31'h7FFFFFFF);
    drain();
    write_reg(CFG_LOOP, 1);
    tick(31'h00010000);
    tick(31'h00018000);
    drain();
    write_reg(CFG_PIVOT_X, 32'h80000000);
    write_reg(CFG_PIVOT_Y, 32'h7FFFFFFF);
    write_reg(CFG_PIVOT_Z, 32'h80000000);
    tick(31'h00004000);
    drain();
    write_reg(CFG_COUNT, 0);
    tick(31'h00010000);
    drain();

    // random phases under changing settings
    for (int ph = 0; ph < 10; ph++) begin
      md = (ph == 0 || ph == 1) ? MODE_DROP : $urandom_range(0, 1);
      gaps_on = (ph % 3 != 2);
      case ($urandom_range(0, 5))
        0: cnt = 0;
        1: cnt = 1;
        2, 3: cnt = $urandom_range(2, 12);
        default: cnt = md == MODE_DROP ? 64 : $urandom_range(1, 8);
      endcase
      if (ph == 0) cnt = 127;
      if (ph == 1) cnt = 64;
      fill_to(cnt);
      write_reg(CFG_MODE, md);
      write_reg(CFG_LOOP, $urandom_range(0, 1));
      write_reg(CFG_PIVOT_X, pick_pivot());
      write_reg(CFG_PIVOT_Y, pick_pivot());
      write_reg(CFG_PIVOT_Z, pick_pivot());
      write_reg(CFG_COUNT, cnt);
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) < 6) begin
          // loads: mostly short lifetimes so loops fire, some at the pivot
          if ($urandom_range(0, 7) == 0)
            load($urandom(), sb.piv[0], sb.piv[1], sb.piv[2], $urandom(),
                 $urandom_range(0, 31'h40000));
          else
            load($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 1) ? $urandom_range(0, 31'h100000) : $urandom());
        end else begin
          case ($urandom_range(0, 3))
            0: tick($urandom());
            1: tick($urandom_range(0, 1) ? 31'h0 : 31'h7FFFFFFF);
            default: tick($urandom_range(0, 31'h40000));
          endcase
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
